### src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// shared constants, command/status types and the digit encoder of the
// radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam int VALUE_W     = 31;
	localparam int RADIX_W     = 5;
	localparam int CHAR_W      = 7;
	localparam int DIGIT_W     = 4;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 8;

	localparam int DIV_W     = 32;
	localparam int DIV_STEPS = 8;
	localparam int DIV_CYC   = DIV_W / DIV_STEPS;
	localparam int CNT_W     = $clog2(DIV_CYC);

	localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO      = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA_OFS = 7'd55;
	localparam logic [DIGIT_W-1:0] DEC_LIMIT       = 4'd10;

	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic rd;
		logic emit;
	} rdc_cmd_t;

	typedef struct packed {
		logic step_last;
		logic quo_zero;
		logic level_zero;
		logic out_free;
	} rdc_status_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = CHAR_W'(d);
		return (d < DEC_LIMIT) ? (ASCII_ZERO + ext) : (ASCII_ALPHA_OFS + ext);
	endfunction

endpackage

### src/rdc_ram.sv
// ----------------------------------------------------------------------------
// rdc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// sequencer of the converter: load, divide loop, then pop and emit loop
// ----------------------------------------------------------------------------
module rdc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rdc_pkg::rdc_status_t st,
	output rdc_pkg::rdc_cmd_t   cmd
);

	import rdc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.step_last) begin
					cmd.push = 1'b1;
					if (st.quo_zero) begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = st.level_zero ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/rdc_dp.sv
// ----------------------------------------------------------------------------
// rdc_dp
// datapath: radix register, iterative divider, digit stack and output register
// ----------------------------------------------------------------------------
module rdc_dp #(
	parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdc_pkg::rdc_cmd_t           cmd,
	output rdc_pkg::rdc_status_t        st,
	input  logic [rdc_pkg::VALUE_W-1:0] in_value,
	input  logic                        cfg_we,
	input  logic [rdc_pkg::RADIX_W-1:0] cfg_radix,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rdc_pkg::CHAR_W-1:0]  out_char,
	output logic                        out_last
);

	import rdc_pkg::*;

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_q;
	logic [RADIX_W-1:0] base_c;
	logic [DIV_W-1:0]   val_q;
	logic [DIV_W-1:0]   val_c;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIGIT_W-1:0] rem_c;
	logic [DIGIT_W:0]   trial;
	logic [CNT_W-1:0]   cnt_q;
	logic [LVL_W-1:0]   level_q;
	logic [LVL_W-1:0]   lvl_dec;
	logic               push_ok;
	logic [DIGIT_W-1:0] rd_digit;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	// radix clamped to 2..16
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base_c = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_c = RADIX_MAX;
		end else begin
			base_c = radix_q;
		end
	end

	// restoring division, several quotient bits per cycle
	always_comb begin
		rem_c = rem_q;
		val_c = val_q;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_c, val_c[DIV_W-1]};
			val_c = {val_c[DIV_W-2:0], 1'b0};
			if (trial >= base_q) begin
				rem_c    = DIGIT_W'(trial - base_q);
				val_c[0] = 1'b1;
			end else begin
				rem_c = trial[DIGIT_W-1:0];
			end
		end
	end

	assign push_ok = cmd.push && (level_q < LVL_W'(STACK_DEPTH));
	assign lvl_dec = level_q - LVL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
			cnt_q   <= '0;
			level_q <= '0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_radix;
			end
			if (cmd.load) begin
				cnt_q   <= '0;
				level_q <= '0;
			end else begin
				if (cmd.div_step) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (push_ok) begin
					level_q <= level_q + LVL_W'(1);
				end else if (cmd.rd) begin
					level_q <= lvl_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= DIV_W'(in_value);
			rem_q  <= '0;
			base_q <= base_c;
		end else if (cmd.div_step) begin
			val_q <= val_c;
			rem_q <= st.step_last ? '0 : rem_c;
		end
	end

	rdc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push_ok),
		.waddr (level_q[AW-1:0]),
		.wdata (rem_c),
		.re    (cmd.rd),
		.raddr (lvl_dec[AW-1:0]),
		.rdata (rd_digit)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= digit_to_ascii(rd_digit);
			out_last_q <= st.level_zero;
		end
	end

	assign st.step_last  = (cnt_q == CNT_W'(DIV_CYC - 1));
	assign st.quo_zero   = (val_c == '0);
	assign st.level_zero = (level_q == '0);
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> level_q < LVL_W'(STACK_DEPTH))
		else $error("push onto full digit stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> level_q != '0)
		else $error("pop from empty digit stack");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (level_q == '0 && cnt_q == '0))
		else $error("stack level or step count not cleared on load");
`endif

endmodule

### src/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// converts a non-negative integer to ascii digits in a programmable radix
// ----------------------------------------------------------------------------
// One value is taken at a time; its digits leave most significant first,
// tlast on the least significant one, and zero gives a single '0'. Each digit
// is worked out in the divider (eight quotient bits a cycle over a 32-bit
// dividend) and pushed onto the digit stack ram, then popped from it through
// the registered read data and emitted. The next value is taken while the
// last digit still waits in the output register. The radix register (reset
// 10, values below 2 act as 2, above 16 as 16) is to be written only while
// the block is idle.
module radix_digit_converter_top #(
	parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // digit_char
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rdc_pkg::RADIX_W-1:0]     cfg_data       // radix
);

	import rdc_pkg::*;

	rdc_cmd_t          cmd;
	rdc_status_t       st;
	logic [CHAR_W-1:0] out_char;

	assign cfg_ready = 1'b1;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rdc_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_value  (s_axis_tdata[VALUE_W-1:0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_radix (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_TDATA_W'(out_char);

endmodule
